[rtl/core/kbm_pkg.sv]
`default_nettype none
package kbm_pkg;

  localparam int NumRows = 8;
  localparam int NumCols = 5;
  localparam int NumExt  = 16;

  localparam logic [NumCols-1:0] ALL_COLS = 5'h1F;
  // Extended IDs that pull Caps Shift and Symbol Shift
  localparam logic [NumExt-1:0]  CS_IDS   = 16'hFF0F;
  localparam logic [NumExt-1:0]  SYM_IDS  = 16'h01F0;

  localparam logic [2:0] CAPS_ROW = 3'd0;
  localparam logic [2:0] CAPS_COL = 3'd0;
  localparam logic [2:0] SYM_ROW  = 3'd7;
  localparam logic [2:0] SYM_COL  = 3'd1;

  // Configuration register indexes
  localparam logic [0:0] REG_CANCEL_FOLD = 1'b0;

  typedef enum logic [1:0] {
    REQ_KEY  = 2'd0,
    REQ_EXT  = 2'd1,
    REQ_SCAN = 2'd2,
    REQ_READ = 2'd3
  } kbm_req_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] key_row;
    logic [2:0] key_col;
    logic [3:0] ext_key_id;
    logic       key_pressed;
    logic [7:0] row_select;
  } kbm_in_t;

  typedef struct packed {
    logic [4:0]  row_data;
    logic [15:0] ext_keys_raw;
  } kbm_out_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] row;
    logic [2:0] col;
  } kbm_pos_t;

  typedef logic [NumRows-1:0][NumCols-1:0] kbm_rows_t;

  // Matrix position that each extended key folds onto; ID 8 folds onto no position
  function automatic kbm_pos_t fold_pos(input logic [3:0] id);
    kbm_pos_t p;
    p.hit = 1'b1;
    unique case (id)
      4'd0:    begin p.row = 3'd4; p.col = 3'd2; end
      4'd1:    begin p.row = 3'd3; p.col = 3'd4; end
      4'd2:    begin p.row = 3'd4; p.col = 3'd4; end
      4'd3:    begin p.row = 3'd4; p.col = 3'd3; end
      4'd4:    begin p.row = 3'd7; p.col = 3'd2; end
      4'd5:    begin p.row = 3'd7; p.col = 3'd3; end
      4'd6:    begin p.row = 3'd5; p.col = 3'd0; end
      4'd7:    begin p.row = 3'd5; p.col = 3'd1; end
      4'd8:    begin p.hit = 1'b0; p.row = 3'd0; p.col = 3'd0; end
      4'd9:    begin p.row = 3'd3; p.col = 3'd1; end
      4'd10:   begin p.row = 3'd4; p.col = 3'd1; end
      4'd11:   begin p.row = 3'd3; p.col = 3'd2; end
      4'd12:   begin p.row = 3'd3; p.col = 3'd3; end
      4'd13:   begin p.row = 3'd7; p.col = 3'd0; end
      4'd14:   begin p.row = 3'd3; p.col = 3'd0; end
      default: begin p.row = 3'd4; p.col = 3'd0; end
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

[rtl/core/keyboard_matrix_with_extended_fold.sv]
// A taken word is captured by the input register, then the result register in kbm_core drives result and result_valid.
// Throughput: one word per cycle, every cycle; busy stays low, so start is never held off.
// Reset (rst, synchronous): all matrix keys released, extended keys clear, shift snapshot
// released, cancel_fold cleared, and no result pending. The receiver cannot stall.
`default_nettype none
module keyboard_matrix_with_extended_fold (
  input  wire logic              clk,
  input  wire logic              rst,
  // Command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire kbm_pkg::kbm_in_t  cmd,
  // Result channel: one cycle strobe, no back-pressure
  output logic                   result_valid,
  output kbm_pkg::kbm_out_t      result,
  // Register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic             in_valid;
  kbm_pkg::kbm_in_t in_word;
  logic             cancel_fold;

  // Every update and read finishes in one pass, so the next word can
  // always follow directly behind.
  assign busy = 1'b0;

  // Input register: capture the word on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word <= cmd;
    end
  end

  kbm_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cancel_fold (cancel_fold)
  );

  // Matrix state, fold and result register
  kbm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (in_valid),
    .item         (in_word),
    .cancel_fold  (cancel_fold),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
`default_nettype wire

[rtl/core/kbm_cfg.sv]
`default_nettype none
module kbm_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             cancel_fold
);

  logic reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == kbm_pkg::REG_CANCEL_FOLD);
  assign wr_en   = psel & penable & pwrite & pready & reg_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      cancel_fold <= 1'b0;
    end else if (wr_en) begin
      cancel_fold <= pwdata[0];
    end
  end

  assign prdata = reg_sel ? {31'd0, cancel_fold} : 32'd0;

endmodule
`default_nettype wire

[rtl/core/kbm_fold.sv]
`default_nettype none
module kbm_fold (
  input  wire logic [15:0]       ext_keys,
  output kbm_pkg::kbm_rows_t     fold_mask
);

  kbm_pkg::kbm_pos_t pos;

  always_comb begin
    fold_mask = '1;
    pos = '0;
    for (int i = 0; i < kbm_pkg::NumExt; i++) begin
      pos = kbm_pkg::fold_pos(4'(i));
      if (ext_keys[i] && pos.hit) begin
        fold_mask[pos.row][pos.col] = 1'b0;
      end
    end
    // Shift modifiers that the extended keys imply
    if ((ext_keys & kbm_pkg::CS_IDS) != '0) begin
      fold_mask[kbm_pkg::CAPS_ROW][kbm_pkg::CAPS_COL] = 1'b0;
    end
    if ((ext_keys & kbm_pkg::SYM_IDS) != '0) begin
      fold_mask[kbm_pkg::SYM_ROW][kbm_pkg::SYM_COL] = 1'b0;
    end
  end

endmodule
`default_nettype wire

[rtl/core/kbm_core.sv]
`default_nettype none
module kbm_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire kbm_pkg::kbm_in_t item,
  input  wire logic             cancel_fold,
  output logic                  result_valid,
  output kbm_pkg::kbm_out_t     result
);

  kbm_pkg::kbm_rows_t key_rows;
  kbm_pkg::kbm_rows_t key_rows_next;
  kbm_pkg::kbm_rows_t fold_mask;
  logic [15:0]        ext_key_bits;
  logic [15:0]        ext_key_bits_next;
  logic [15:0]        ext_gated;
  logic [1:0]         shift_snapshot;
  logic [1:0]         shift_snapshot_next;
  kbm_pkg::kbm_req_t  req;
  logic [4:0]         col_bit;
  logic [15:0]        id_bit;
  logic [4:0]         row_val;
  logic [4:0]         read_data;
  kbm_pkg::kbm_out_t  result_next;

  assign ext_gated = cancel_fold ? 16'd0 : ext_key_bits;

  kbm_fold u_fold (
    .ext_keys  (ext_gated),
    .fold_mask (fold_mask)
  );

  always_comb begin
    req     = kbm_pkg::kbm_req_t'(item.req_type);
    col_bit = (item.key_col <= 3'd4) ? (5'b00001 << item.key_col) : 5'd0;
    id_bit  = 16'd1 << item.ext_key_id;

    key_rows_next       = key_rows;
    ext_key_bits_next   = ext_key_bits;
    shift_snapshot_next = shift_snapshot;
    read_data           = kbm_pkg::ALL_COLS;
    row_val             = kbm_pkg::ALL_COLS;

    unique case (req)
      kbm_pkg::REQ_KEY: begin
        for (int i = 0; i < kbm_pkg::NumRows; i++) begin
          if (item.key_row == 3'(i)) begin
            key_rows_next[i] = item.key_pressed ? (key_rows[i] & ~col_bit)
                                                : (key_rows[i] | col_bit);
          end
        end
      end
      kbm_pkg::REQ_EXT: begin
        ext_key_bits_next = item.key_pressed ? (ext_key_bits | id_bit)
                                             : (ext_key_bits & ~id_bit);
      end
      kbm_pkg::REQ_SCAN: begin
        shift_snapshot_next = {key_rows[kbm_pkg::SYM_ROW][kbm_pkg::SYM_COL],
                               key_rows[kbm_pkg::CAPS_ROW][kbm_pkg::CAPS_COL]};
      end
      default: begin
        // AND every selected row, with shift hysteresis and fold applied
        for (int i = 0; i < kbm_pkg::NumRows; i++) begin
          row_val = key_rows[i];
          if (i == 0 && !shift_snapshot[0]) begin
            row_val[kbm_pkg::CAPS_COL] = 1'b0;
          end
          if (i == 7 && !shift_snapshot[1]) begin
            row_val[kbm_pkg::SYM_COL] = 1'b0;
          end
          if (!item.row_select[i]) begin
            read_data = read_data & row_val & fold_mask[i];
          end
        end
      end
    endcase

    result_next.row_data     = read_data;
    result_next.ext_keys_raw = ext_key_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rows       <= '1;
      ext_key_bits   <= '0;
      shift_snapshot <= 2'b11;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= item_valid;
      if (item_valid) begin
        key_rows       <= key_rows_next;
        ext_key_bits   <= ext_key_bits_next;
        shift_snapshot <= shift_snapshot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire
